// File: rtl/msfr_pkg.sv
package msfr_pkg;

  localparam int unsigned MaxFrameBytes = 256;
  // header, version, command, two length bytes and checksum around the payload
  localparam int unsigned FrameOverhead = 7;

  localparam logic [7:0]  HdrByte0 = 8'h55;
  localparam logic [7:0]  HdrByte1 = 8'hAA;
  localparam logic [7:0]  HdrSum   = HdrByte0 + HdrByte1;
  localparam logic [23:0] TickMax  = 24'hFF_FFFF;

  localparam logic [31:0] SetpointRst = 32'd22;
  localparam logic [31:0] MeasuredRst = 32'd20;
  localparam logic [7:0]  ModeRst     = 8'd0;

  typedef enum logic [3:0] {
    PH_H0,
    PH_H1,
    PH_VER,
    PH_CMD,
    PH_LH,
    PH_LL,
    PH_DID,
    PH_DTYPE,
    PH_DLH,
    PH_DLL,
    PH_DVAL,
    PH_SKIP,
    PH_CSUM
  } phase_e;

  typedef enum logic [1:0] {
    ST_APPLIED,
    ST_OTHER_CMD,
    ST_BAD_SUM,
    ST_TOO_LONG
  } status_e;

  typedef enum logic [2:0] {
    CFG_POWER_ID,
    CFG_SETPOINT_ID,
    CFG_MEASURED_ID,
    CFG_MODE_ID,
    CFG_DISPLAY_ID,
    CFG_REPORT_CMD,
    CFG_WINDOW,
    CFG_LIMIT
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  power_id;
    logic [7:0]  setpoint_id;
    logic [7:0]  measured_id;
    logic [7:0]  mode_id;
    logic [7:0]  display_id;
    logic [7:0]  report_cmd;
    logic [23:0] window;
    logic [7:0]  limit;
  } cfg_t;

  // events from the parser toward the state keeper
  typedef struct packed {
    logic        start;
    logic        apply;
    logic [7:0]  point_id;
    logic [31:0] point_val;
    logic        done;
    status_e     status;
    logic        commit;
  } ev_t;

  typedef struct packed {
    logic        valid;
    status_e     status;
    logic        power;
    logic [31:0] setpoint;
    logic [31:0] measured;
    logic [7:0]  mode;
    logic        display;
    logic        changed;
    logic        rst_req;
  } res_t;

endpackage

// File: rtl/msfr_parser.sv
module msfr_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_acc_i,
  input  logic [7:0]        rx_byte_i,
  input  msfr_pkg::cfg_t    cfg_i,
  output msfr_pkg::ev_t     ev_o
);
  import msfr_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  pid_q, pid_d;
  logic [15:0] plen_q, plen_d;
  logic [15:0] pidx_q, pidx_d;
  logic [31:0] acc_q, acc_d;

  logic [15:0] cnt_inc, remaining, len_full, plen_full, pidx_inc;
  logic [31:0] acc_shift;
  logic        pt_last, is_report, too_long, pt_cut;

  assign cnt_inc   = cnt_q + 16'd1;
  assign remaining = len_q - cnt_inc;
  assign len_full  = {len_q[15:8], rx_byte_i};
  assign plen_full = {plen_q[15:8], rx_byte_i};
  assign pidx_inc  = pidx_q + 16'd1;
  assign acc_shift = {acc_q[23:0], rx_byte_i};
  assign pt_last   = (pidx_inc == plen_q);
  assign pt_cut    = (plen_full > remaining);
  assign is_report = (cmd_q == cfg_i.report_cmd);
  assign too_long  = ({1'b0, len_full} + 17'(FrameOverhead)) > 17'(MaxFrameBytes);

  always_comb begin
    phase_d = phase_q;
    if (byte_acc_i) begin
      case (phase_q)
        PH_H0: begin
          if (rx_byte_i == HdrByte0) phase_d = PH_H1;
        end
        PH_H1: begin
          if (rx_byte_i == HdrByte1) phase_d = PH_VER;
          else if (rx_byte_i != HdrByte0) phase_d = PH_H0;
        end
        PH_CSUM: phase_d = PH_H0;
        PH_VER:  phase_d = PH_CMD;
        PH_CMD:  phase_d = PH_LH;
        PH_LH:   phase_d = PH_LL;
        PH_LL: begin
          if (too_long) phase_d = PH_H0;
          else if (len_full == 16'd0) phase_d = PH_CSUM;
          else if (is_report) phase_d = PH_DID;
          else phase_d = PH_SKIP;
        end
        default: begin
          case (phase_q)
            PH_DID:   phase_d = PH_DTYPE;
            PH_DTYPE: phase_d = PH_DLH;
            PH_DLH:   phase_d = PH_DLL;
            PH_DLL: begin
              if (pt_cut) phase_d = PH_SKIP;
              else if (plen_full == 16'd0) phase_d = PH_DID;
              else phase_d = PH_DVAL;
            end
            PH_DVAL: begin
              if (pt_last) phase_d = PH_DID;
            end
            default: phase_d = phase_q;
          endcase
          if (cnt_inc == len_q) phase_d = PH_CSUM;
        end
      endcase
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    len_d  = len_q;
    sum_d  = sum_q;
    cmd_d  = cmd_q;
    pid_d  = pid_q;
    plen_d = plen_q;
    pidx_d = pidx_q;
    acc_d  = acc_q;
    ev_o   = '0;
    if (byte_acc_i) begin
      case (phase_q)
        PH_H0: ;
        PH_H1: begin
          if (rx_byte_i == HdrByte1) begin
            ev_o.start = 1'b1;
            sum_d      = HdrSum;
            cnt_d      = '0;
            len_d      = '0;
          end
        end
        PH_CSUM: begin
          ev_o.done = 1'b1;
          if (rx_byte_i != sum_q) begin
            ev_o.status = ST_BAD_SUM;
          end else if (!is_report) begin
            ev_o.status = ST_OTHER_CMD;
          end else begin
            ev_o.status = ST_APPLIED;
            ev_o.commit = 1'b1;
          end
        end
        default: begin
          sum_d = sum_q + rx_byte_i;
          case (phase_q)
            PH_VER: ;
            PH_CMD: cmd_d = rx_byte_i;
            PH_LH:  len_d = {rx_byte_i, 8'h00};
            PH_LL: begin
              len_d = len_full;
              cnt_d = '0;
              if (too_long) begin
                ev_o.done   = 1'b1;
                ev_o.status = ST_TOO_LONG;
              end
            end
            default: begin
              cnt_d = cnt_inc;
              case (phase_q)
                PH_DID: pid_d = rx_byte_i;
                PH_DLH: plen_d = {rx_byte_i, 8'h00};
                PH_DLL: begin
                  plen_d = plen_full;
                  if (!pt_cut) begin
                    if (plen_full == 16'd0) begin
                      ev_o.apply    = 1'b1;
                      ev_o.point_id = pid_q;
                    end else begin
                      pidx_d = '0;
                      acc_d  = '0;
                    end
                  end
                end
                PH_DVAL: begin
                  acc_d  = acc_shift;
                  pidx_d = pidx_inc;
                  if (pt_last) begin
                    ev_o.apply    = 1'b1;
                    ev_o.point_id = pid_q;
                    // only one- and four-byte values are taken as numbers
                    if (plen_q == 16'd1 || plen_q == 16'd4) ev_o.point_val = acc_shift;
                  end
                end
                default: ;
              endcase
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_H0;
      cnt_q   <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      cmd_q   <= '0;
      pid_q   <= '0;
      plen_q  <= '0;
      pidx_q  <= '0;
      acc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      cmd_q   <= cmd_d;
      pid_q   <= pid_d;
      plen_q  <= plen_d;
      pidx_q  <= pidx_d;
      acc_q   <= acc_d;
    end
  end

endmodule

// File: rtl/msfr_state.sv
module msfr_state (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_acc_i,
  input  msfr_pkg::ev_t     ev_i,
  input  msfr_pkg::cfg_t    cfg_i,
  output msfr_pkg::res_t    res_o
);
  import msfr_pkg::*;

  logic        sh_pow_q, sh_pow_d;
  logic [31:0] sh_set_q, sh_set_d;
  logic [31:0] sh_meas_q, sh_meas_d;
  logic [7:0]  sh_mode_q, sh_mode_d;
  logic        sh_disp_q, sh_disp_d;
  logic [7:0]  sh_tog_q, sh_tog_d;
  logic        sh_rflag_q, sh_rflag_d;
  logic        toggled_q, toggled_d;
  logic        sh_chg_q, sh_chg_d;
  logic        cm_pow_q, cm_pow_d;
  logic [31:0] cm_set_q, cm_set_d;
  logic [31:0] cm_meas_q, cm_meas_d;
  logic [7:0]  cm_mode_q, cm_mode_d;
  logic        cm_disp_q, cm_disp_d;
  logic [7:0]  cm_tog_q, cm_tog_d;
  logic [23:0] ticks_q, ticks_d;

  logic        new_pow, new_disp;
  logic [7:0]  tog_cnt;

  assign new_pow  = (ev_i.point_val == 32'd1);
  assign new_disp = (ev_i.point_val == 32'd0);
  // toggles inside the window or inside this frame keep counting
  assign tog_cnt  = (toggled_q || ticks_q < cfg_i.window) ? sh_tog_q + 8'd1 : 8'd1;

  always_comb begin
    sh_pow_d   = sh_pow_q;
    sh_set_d   = sh_set_q;
    sh_meas_d  = sh_meas_q;
    sh_mode_d  = sh_mode_q;
    sh_disp_d  = sh_disp_q;
    sh_tog_d   = sh_tog_q;
    sh_rflag_d = sh_rflag_q;
    toggled_d  = toggled_q;
    sh_chg_d   = sh_chg_q;
    cm_pow_d   = cm_pow_q;
    cm_set_d   = cm_set_q;
    cm_meas_d  = cm_meas_q;
    cm_mode_d  = cm_mode_q;
    cm_disp_d  = cm_disp_q;
    cm_tog_d   = cm_tog_q;
    ticks_d    = ticks_q;

    if (tick_acc_i && ticks_q != TickMax) ticks_d = ticks_q + 24'd1;

    if (ev_i.start) begin
      sh_pow_d   = cm_pow_q;
      sh_set_d   = cm_set_q;
      sh_meas_d  = cm_meas_q;
      sh_mode_d  = cm_mode_q;
      sh_disp_d  = cm_disp_q;
      sh_tog_d   = cm_tog_q;
      sh_rflag_d = 1'b0;
      toggled_d  = 1'b0;
      sh_chg_d   = 1'b0;
    end

    if (ev_i.apply) begin
      if (ev_i.point_id == cfg_i.power_id) begin
        if (new_pow != sh_pow_q) begin
          toggled_d = 1'b1;
          sh_pow_d  = new_pow;
          sh_chg_d  = 1'b1;
          if (tog_cnt >= cfg_i.limit) begin
            sh_rflag_d = 1'b1;
            sh_tog_d   = '0;
          end else begin
            sh_tog_d = tog_cnt;
          end
        end
      end else if (ev_i.point_id == cfg_i.setpoint_id) begin
        if (sh_set_q != ev_i.point_val) begin
          sh_set_d = ev_i.point_val;
          sh_chg_d = 1'b1;
        end
      end else if (ev_i.point_id == cfg_i.measured_id) begin
        if (sh_meas_q != ev_i.point_val) begin
          sh_meas_d = ev_i.point_val;
          sh_chg_d  = 1'b1;
        end
      end else if (ev_i.point_id == cfg_i.mode_id) begin
        // change test on the full value, only the low byte is kept
        if ({24'd0, sh_mode_q} != ev_i.point_val) begin
          sh_mode_d = ev_i.point_val[7:0];
          sh_chg_d  = 1'b1;
        end
      end else if (ev_i.point_id == cfg_i.display_id) begin
        if (sh_disp_q != new_disp) begin
          sh_disp_d = new_disp;
          sh_chg_d  = 1'b1;
        end
      end
    end

    if (ev_i.commit) begin
      cm_pow_d  = sh_pow_q;
      cm_set_d  = sh_set_q;
      cm_meas_d = sh_meas_q;
      cm_mode_d = sh_mode_q;
      cm_disp_d = sh_disp_q;
      cm_tog_d  = sh_tog_q;
      if (toggled_q) ticks_d = '0;
    end
  end

  always_comb begin
    res_o          = '0;
    res_o.valid    = ev_i.done;
    res_o.status   = ev_i.status;
    res_o.power    = cm_pow_d;
    res_o.setpoint = cm_set_d;
    res_o.measured = cm_meas_d;
    res_o.mode     = cm_mode_d;
    res_o.display  = cm_disp_d;
    res_o.changed  = ev_i.commit & sh_chg_q;
    res_o.rst_req  = ev_i.commit & sh_rflag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_pow_q   <= 1'b0;
      sh_set_q   <= SetpointRst;
      sh_meas_q  <= MeasuredRst;
      sh_mode_q  <= ModeRst;
      sh_disp_q  <= 1'b1;
      sh_tog_q   <= '0;
      sh_rflag_q <= 1'b0;
      toggled_q  <= 1'b0;
      sh_chg_q   <= 1'b0;
      cm_pow_q   <= 1'b0;
      cm_set_q   <= SetpointRst;
      cm_meas_q  <= MeasuredRst;
      cm_mode_q  <= ModeRst;
      cm_disp_q  <= 1'b1;
      cm_tog_q   <= '0;
      ticks_q    <= '0;
    end else begin
      sh_pow_q   <= sh_pow_d;
      sh_set_q   <= sh_set_d;
      sh_meas_q  <= sh_meas_d;
      sh_mode_q  <= sh_mode_d;
      sh_disp_q  <= sh_disp_d;
      sh_tog_q   <= sh_tog_d;
      sh_rflag_q <= sh_rflag_d;
      toggled_q  <= toggled_d;
      sh_chg_q   <= sh_chg_d;
      cm_pow_q   <= cm_pow_d;
      cm_set_q   <= cm_set_d;
      cm_meas_q  <= cm_meas_d;
      cm_mode_q  <= cm_mode_d;
      cm_disp_q  <= cm_disp_d;
      cm_tog_q   <= cm_tog_d;
      ticks_q    <= ticks_d;
    end
  end

endmodule

// File: rtl/msfr_out_skid.sv
module msfr_out_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msfr_pkg::res_t    push_i,
  input  logic              out_stall_i,
  output msfr_pkg::res_t    out_o,
  output logic              full_o
);
  import msfr_pkg::*;

  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop = out_q.valid && !out_stall_i;

  always_comb begin
    out_d  = out_q;
    skid_d = skid_q;
    if (!out_q.valid || pop) begin
      if (skid_q.valid) begin
        out_d  = skid_q;
        skid_d = push_i;
      end else begin
        out_d = push_i;
      end
    end else if (push_i.valid) begin
      // output beat held, park the new result
      skid_d = push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q  <= '0;
      skid_q <= '0;
    end else begin
      out_q  <= out_d;
      skid_q <= skid_d;
    end
  end

  assign out_o  = out_q;
  assign full_o = skid_q.valid;

endmodule

// File: rtl/mcu_status_frame_receiver.sv
// channel   direction  handshake                  payload
// cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_stall_o    req_type_i, rx_byte_i
// out       out        out_valid_o / out_stall_i  frame_status_o .. reset_request_o
//
// one item per cycle while in_stall_o is low: a byte or tick is consumed in the cycle it is accepted,
// and a frame result is registered in the output stage, or in the second stage behind an earlier result.
// a second output stage takes a result while the output beat is stalled;
// in_stall_o rises only when both output stages are full.
// reset puts the parser in header hunt and the heater state to its defaults.
module mcu_status_frame_receiver (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         frame_status_o,
  output logic               power_on_o,
  output logic signed [31:0] target_temp_o,
  output logic signed [31:0] current_temp_o,
  output logic [7:0]         heat_mode_o,
  output logic               display_on_o,
  output logic               state_changed_o,
  output logic               reset_request_o
);
  import msfr_pkg::*;

  cfg_t cfg_q, cfg_d;
  ev_t  ev;
  res_t res, out;
  logic in_acc, byte_acc, tick_acc, skid_full;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign byte_acc    = in_acc && !req_type_i;
  assign tick_acc    = in_acc && req_type_i;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_POWER_ID:    cfg_d.power_id    = cfg_data_i[7:0];
        CFG_SETPOINT_ID: cfg_d.setpoint_id = cfg_data_i[7:0];
        CFG_MEASURED_ID: cfg_d.measured_id = cfg_data_i[7:0];
        CFG_MODE_ID:     cfg_d.mode_id     = cfg_data_i[7:0];
        CFG_DISPLAY_ID:  cfg_d.display_id  = cfg_data_i[7:0];
        CFG_REPORT_CMD:  cfg_d.report_cmd  = cfg_data_i[7:0];
        CFG_WINDOW:      cfg_d.window      = cfg_data_i;
        CFG_LIMIT:       cfg_d.limit       = cfg_data_i[7:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_id    <= 8'd1;
      cfg_q.setpoint_id <= 8'd2;
      cfg_q.measured_id <= 8'd3;
      cfg_q.mode_id     <= 8'd4;
      cfg_q.display_id  <= 8'd5;
      cfg_q.report_cmd  <= 8'h07;
      cfg_q.window      <= 24'd3000;
      cfg_q.limit       <= 8'd10;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  msfr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_acc_i (byte_acc),
    .rx_byte_i  (rx_byte_i),
    .cfg_i      (cfg_q),
    .ev_o       (ev)
  );

  msfr_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_acc_i (tick_acc),
    .ev_i       (ev),
    .cfg_i      (cfg_q),
    .res_o      (res)
  );

  msfr_out_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res),
    .out_stall_i (out_stall_i),
    .out_o       (out),
    .full_o      (skid_full)
  );

  assign in_stall_o      = skid_full;
  assign out_valid_o     = out.valid;
  assign frame_status_o  = out.status;
  assign power_on_o      = out.power;
  assign target_temp_o   = $signed(out.setpoint);
  assign current_temp_o  = $signed(out.measured);
  assign heat_mode_o     = out.mode;
  assign display_on_o    = out.display;
  assign state_changed_o = out.changed;
  assign reset_request_o = out.rst_req;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full |-> out_valid_o)
    else $error("skid stage holds a beat while output stage is empty");

  a_flags_only_applied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o != ST_APPLIED) |-> (!state_changed_o && !reset_request_o))
    else $error("change or reset flag on a frame that was not applied");

  a_tick_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |-> !res.valid)
    else $error("tick produced a frame result");

  a_commit_is_applied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev.commit |-> (ev.done && ev.status == ST_APPLIED))
    else $error("commit without an applied frame result");
`endif

endmodule

// File: sim/msfr_tracker_pkg.sv
package msfr_tracker_pkg;
  import msfr_pkg::*;

  // mirrors the frame parser and heater state, queues the expected status beats
  class status_frame_tracker;
    cfg_t        cfg;
    phase_e      phase;
    logic [15:0] byte_cnt, decl_len, point_len, point_idx;
    logic [7:0]  sum, cmd, point_id;
    logic [31:0] acc;

    logic        sh_power, sh_display, sh_rst, toggled, sh_changed;
    logic [31:0] sh_setpoint, sh_measured;
    logic [7:0]  sh_mode, sh_toggles;

    logic        c_power, c_display;
    logic [31:0] c_setpoint, c_measured;
    logic [7:0]  c_mode, c_toggles;
    logic [23:0] ticks;

    res_t        expected_q[$];
    int unsigned mismatches;

    function new();
      cfg = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd7, 24'd3000, 8'd10};
      phase = PH_H0;
      cmd = '0;
      point_id = '0;
      point_len = '0;
      point_idx = '0;
      acc = '0;
      c_power = 1'b0;
      c_setpoint = SetpointRst;
      c_measured = MeasuredRst;
      c_mode = ModeRst;
      c_display = 1'b1;
      c_toggles = '0;
      ticks = '0;
      open_frame();
      sum = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [23:0] d);
      case (idx)
        CFG_POWER_ID:    cfg.power_id = d[7:0];
        CFG_SETPOINT_ID: cfg.setpoint_id = d[7:0];
        CFG_MEASURED_ID: cfg.measured_id = d[7:0];
        CFG_MODE_ID:     cfg.mode_id = d[7:0];
        CFG_DISPLAY_ID:  cfg.display_id = d[7:0];
        CFG_REPORT_CMD:  cfg.report_cmd = d[7:0];
        CFG_WINDOW:      cfg.window = d;
        default:         cfg.limit = d[7:0];
      endcase
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    function void open_frame();
      sum = HdrByte0;
      byte_cnt = '0;
      decl_len = '0;
      sh_power = c_power;
      sh_setpoint = c_setpoint;
      sh_measured = c_measured;
      sh_mode = c_mode;
      sh_display = c_display;
      sh_toggles = c_toggles;
      sh_rst = 1'b0;
      toggled = 1'b0;
      sh_changed = 1'b0;
    endfunction

    function void push_status(status_e st, logic chg, logic rq);
      res_t r;
      r.valid = 1'b1;
      r.status = st;
      r.power = c_power;
      r.setpoint = c_setpoint;
      r.measured = c_measured;
      r.mode = c_mode;
      r.display = c_display;
      r.changed = chg;
      r.rst_req = rq;
      expected_q.push_back(r);
    endfunction

    function void apply_point(logic [7:0] id, logic [31:0] val);
      logic np;
      logic on;
      np = (val == 32'd1);
      on = (val == 32'd0);
      if (id == cfg.power_id) begin
        if (np != sh_power) begin
          if (toggled || ticks < cfg.window) sh_toggles = sh_toggles + 8'd1;
          else sh_toggles = 8'd1;
          toggled = 1'b1;
          if (sh_toggles >= cfg.limit) begin
            sh_rst = 1'b1;
            sh_toggles = '0;
          end
          sh_power = np;
          sh_changed = 1'b1;
        end
      end else if (id == cfg.setpoint_id) begin
        if (sh_setpoint != val) begin
          sh_setpoint = val;
          sh_changed = 1'b1;
        end
      end else if (id == cfg.measured_id) begin
        if (sh_measured != val) begin
          sh_measured = val;
          sh_changed = 1'b1;
        end
      end else if (id == cfg.mode_id) begin
        // change test sees all 32 bits, only the low byte is kept
        if ({24'd0, sh_mode} != val) begin
          sh_mode = val[7:0];
          sh_changed = 1'b1;
        end
      end else if (id == cfg.display_id) begin
        if (sh_display != on) begin
          sh_display = on;
          sh_changed = 1'b1;
        end
      end
    endfunction

    function void payload_byte(logic [7:0] b);
      logic [15:0] remaining;
      byte_cnt = byte_cnt + 16'd1;
      remaining = decl_len - byte_cnt;
      case (phase)
        PH_DID: begin
          point_id = b;
          phase = PH_DTYPE;
        end
        PH_DTYPE: phase = PH_DLH;
        PH_DLH: begin
          point_len = {b, 8'h00};
          phase = PH_DLL;
        end
        PH_DLL: begin
          point_len = {point_len[15:8], b};
          if (point_len > remaining) begin
            phase = PH_SKIP;
          end else if (point_len == 16'd0) begin
            apply_point(point_id, 32'd0);
            phase = PH_DID;
          end else begin
            point_idx = '0;
            acc = '0;
            phase = PH_DVAL;
          end
        end
        PH_DVAL: begin
          acc = {acc[23:0], b};
          point_idx = point_idx + 16'd1;
          if (point_idx == point_len) begin
            apply_point(point_id, (point_len == 16'd1 || point_len == 16'd4) ? acc : 32'd0);
            phase = PH_DID;
          end
        end
        default: ;
      endcase
      if (byte_cnt == decl_len) phase = PH_CSUM;
    endfunction

    function void take_item(logic is_tick, logic [7:0] b);
      if (is_tick) begin
        if (ticks != TickMax) ticks = ticks + 24'd1;
        return;
      end
      case (phase)
        PH_H0: begin
          if (b == HdrByte0) phase = PH_H1;
          return;
        end
        PH_H1: begin
          if (b == HdrByte1) begin
            open_frame();
            sum = HdrSum;
            phase = PH_VER;
          end else if (b != HdrByte0) begin
            phase = PH_H0;
          end
          return;
        end
        PH_CSUM: begin
          phase = PH_H0;
          if (b != sum) begin
            push_status(ST_BAD_SUM, 1'b0, 1'b0);
          end else if (cmd != cfg.report_cmd) begin
            push_status(ST_OTHER_CMD, 1'b0, 1'b0);
          end else begin
            c_power = sh_power;
            c_setpoint = sh_setpoint;
            c_measured = sh_measured;
            c_mode = sh_mode;
            c_display = sh_display;
            c_toggles = sh_toggles;
            if (toggled) ticks = '0;
            push_status(ST_APPLIED, sh_changed, sh_rst);
          end
          return;
        end
        default: ;
      endcase
      sum = sum + b;
      case (phase)
        PH_VER: phase = PH_CMD;
        PH_CMD: begin
          cmd = b;
          phase = PH_LH;
        end
        PH_LH: begin
          decl_len = {b, 8'h00};
          phase = PH_LL;
        end
        PH_LL: begin
          decl_len = {decl_len[15:8], b};
          byte_cnt = '0;
          if (FrameOverhead + decl_len > MaxFrameBytes) begin
            phase = PH_H0;
            push_status(ST_TOO_LONG, 1'b0, 1'b0);
          end else if (decl_len == 16'd0) begin
            phase = PH_CSUM;
          end else begin
            phase = (cmd == cfg.report_cmd) ? PH_DID : PH_SKIP;
          end
        end
        default: payload_byte(b);
      endcase
    endfunction

    function string show(res_t r);
      return $sformatf("st=%0d pwr=%0b set=%0d meas=%0d mode=%0d disp=%0b chg=%0b rst=%0b",
                       r.status, r.power, $signed(r.setpoint), $signed(r.measured),
                       r.mode, r.display, r.changed, r.rst_req);
    endfunction

    function void match_status(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected status beat: %s", show(got));
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("status beat mismatch, expected: %s", show(want));
          $display("                        actual: %s", show(got));
        end
      end
    endfunction
  endclass

endpackage

// File: sim/tb_mcu_status_frame_receiver.sv
module tb_mcu_status_frame_receiver;
  import msfr_pkg::*;
  import msfr_tracker_pkg::*;

  localparam int unsigned IdlePct    = 29;
  localparam int unsigned HoldCycles = 160;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemGoal   = 650;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [23:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               req_type_i = 1'b0;
  logic [7:0]         rx_byte_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         frame_status_o;
  logic               power_on_o;
  logic signed [31:0] target_temp_o;
  logic signed [31:0] current_temp_o;
  logic [7:0]         heat_mode_o;
  logic               display_on_o;
  logic               state_changed_o;
  logic               reset_request_o;

  status_frame_tracker tracker;
  logic [7:0]  payload_q[$];
  int unsigned items_sent = 0;
  int unsigned cycle_cnt;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  mcu_status_frame_receiver dut (.*);

  always #10 clk_i = ~clk_i;

  initial begin : watchdog
    for (cycle_cnt = 0; cycle_cnt < CycleLimit; cycle_cnt++) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  // receiver side: random stall, plus one long hold-off on request
  initial begin : receiver
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= !quiet && ($urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk_i) begin : status_monitor
    res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.valid = 1'b1;
      got.status = status_e'(frame_status_o);
      got.power = power_on_o;
      got.setpoint = target_temp_o;
      got.measured = current_temp_o;
      got.mode = heat_mode_o;
      got.display = display_on_o;
      got.changed = state_changed_o;
      got.rst_req = reset_request_o;
      tracker.match_status(got);
    end
  end

  task automatic send_item(logic is_tick, logic [7:0] b);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= is_tick;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_item(is_tick, b);
    items_sent++;
  endtask

  // ticks may fall between any two bytes of a frame
  task automatic put_byte(logic [7:0] b);
    if ($urandom_range(99) < 6) send_item(1'b1, 8'($urandom));
    send_item(1'b0, b);
  endtask

  task automatic send_frame(logic [7:0] cmd, bit good);
    logic [7:0]  ver;
    logic [7:0]  sum;
    logic [15:0] len;
    ver = 8'($urandom);
    len = 16'(payload_q.size());
    sum = HdrSum + ver + cmd + len[15:8] + len[7:0];
    foreach (payload_q[i]) sum = sum + payload_q[i];
    put_byte(HdrByte0);
    put_byte(HdrByte1);
    put_byte(ver);
    put_byte(cmd);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    foreach (payload_q[i]) put_byte(payload_q[i]);
    put_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic send_oversize(logic [15:0] len);
    put_byte(HdrByte0);
    put_byte(HdrByte1);
    put_byte(8'($urandom));
    put_byte(($urandom_range(1) == 0) ? tracker.cfg.report_cmd : 8'($urandom));
    put_byte(len[15:8]);
    put_byte(len[7:0]);
  endtask

  task automatic add_point(logic [7:0] id, logic [15:0] len, logic [31:0] val);
    payload_q.push_back(id);
    payload_q.push_back(8'($urandom));
    payload_q.push_back(len[15:8]);
    payload_q.push_back(len[7:0]);
    if (len == 16'd4) begin
      payload_q.push_back(val[31:24]);
      payload_q.push_back(val[23:16]);
      payload_q.push_back(val[15:8]);
      payload_q.push_back(val[7:0]);
    end else if (len == 16'd1) begin
      payload_q.push_back(val[7:0]);
    end else begin
      repeat (len) payload_q.push_back(8'($urandom));
    end
  endtask

  function automatic logic [7:0] pick_point_id();
    case ($urandom_range(5))
      0:       return tracker.cfg.power_id;
      1:       return tracker.cfg.setpoint_id;
      2:       return tracker.cfg.measured_id;
      3:       return tracker.cfg.mode_id;
      4:       return tracker.cfg.display_id;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic make_points();
    int unsigned n;
    int unsigned k;
    logic [7:0]  id;
    logic [15:0] len;
    logic [31:0] val;
    payload_q.delete();
    n = $urandom_range(0, 4);
    repeat (n) begin
      id = pick_point_id();
      k = $urandom_range(99);
      if (k < 50) len = 16'd1;
      else if (k < 75) len = 16'd4;
      else if (k < 82) len = 16'd0;
      else if (k < 91) len = 16'($urandom_range(2, 3));
      else len = 16'($urandom_range(5, 8));
      val = ($urandom_range(99) < 60) ? 32'($urandom_range(0, 2)) : 32'($urandom);
      // same low byte as the stored mode but upper bits set still counts as a change
      if (id == tracker.cfg.mode_id && $urandom_range(3) == 0) begin
        len = 16'd4;
        val = {24'($urandom_range(1, 255)), tracker.c_mode};
      end
      add_point(id, len, val);
    end
    // cut the payload short, possibly inside a datapoint, or leave junk after the points
    if (payload_q.size() > 0 && $urandom_range(99) < 10) begin
      n = $urandom_range(0, payload_q.size() - 1);
      while (payload_q.size() > n) void'(payload_q.pop_back());
    end else if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(1, 4)) payload_q.push_back(8'($urandom));
    end
  endtask

  task automatic send_long_frame();
    payload_q.delete();
    while (payload_q.size() + 5 <= MaxFrameBytes - FrameOverhead)
      add_point(pick_point_id(), 16'd1, 32'($urandom_range(0, 3)));
    while (payload_q.size() < MaxFrameBytes - FrameOverhead) payload_q.push_back(8'($urandom));
    send_frame(tracker.cfg.report_cmd, 1'b1);
  endtask

  task automatic random_event();
    int unsigned k;
    int unsigned r;
    logic [7:0]  cmd;
    r = $urandom_range(99);
    if (r < 62) begin
      make_points();
      cmd = ($urandom_range(99) < 85) ? tracker.cfg.report_cmd : 8'($urandom);
      send_frame(cmd, $urandom_range(99) < 82);
    end else if (r < 70) begin
      payload_q.delete();
      repeat ($urandom_range(0, 6)) payload_q.push_back(8'($urandom));
      send_frame(8'($urandom), $urandom_range(99) < 70);
    end else if (r < 77) begin
      k = $urandom_range(99);
      if (k < 30) send_oversize(16'(MaxFrameBytes - FrameOverhead + 1));
      else if (k < 45) send_oversize(16'hFFFF);
      else send_oversize({8'($urandom_range(1, 255)), 8'($urandom)});
    end else if (r < 85) begin
      repeat ($urandom_range(1, 5)) begin
        k = $urandom_range(2);
        put_byte(k == 0 ? HdrByte0 : k == 1 ? HdrByte1 : 8'($urandom));
      end
    end else if (r < 93) begin
      repeat ($urandom_range(1, 40)) send_item(1'b1, 8'($urandom));
    end else begin
      // header and length, then fewer payload bytes than declared
      k = $urandom_range(4, 12);
      put_byte(HdrByte0);
      put_byte(HdrByte1);
      put_byte(8'($urandom));
      put_byte(tracker.cfg.report_cmd);
      put_byte(8'h00);
      put_byte(8'(k));
      repeat ($urandom_range(0, k - 1)) put_byte(8'($urandom));
    end
  endtask

  task automatic run_traffic(int unsigned n);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n) random_event();
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_reg(idx, d);
  endtask

  // finish any open frame, let every status beat drain, then reprogram
  task automatic reprogram(cfg_t c);
    while (tracker.phase != PH_H0) send_item(1'b0, 8'h00);
    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(CFG_POWER_ID,    {16'($urandom), c.power_id});
    write_reg(CFG_SETPOINT_ID, {16'($urandom), c.setpoint_id});
    write_reg(CFG_MEASURED_ID, {16'($urandom), c.measured_id});
    write_reg(CFG_MODE_ID,     {16'($urandom), c.mode_id});
    write_reg(CFG_DISPLAY_ID,  {16'($urandom), c.display_id});
    write_reg(CFG_REPORT_CMD,  {16'($urandom), c.report_cmd});
    write_reg(CFG_WINDOW,      c.window);
    write_reg(CFG_LIMIT,       {16'($urandom), c.limit});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t        c;
    logic [7:0]  base;
    base = 8'($urandom);
    c.power_id = base;
    c.setpoint_id = base + 8'd1;
    c.measured_id = base + 8'd2;
    c.mode_id = base + 8'd3;
    c.display_id = base + 8'($urandom_range(3, 4));
    c.report_cmd = 8'($urandom);
    c.window = 24'($urandom_range(1, 60));
    c.limit = 8'($urandom_range(1, 6));
    return c;
  endfunction

  initial begin : stimulus
    cfg_t c;
    tracker = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // doubled first header byte, then a report that turns power on
    payload_q.delete();
    add_point(tracker.cfg.power_id, 16'd1, 32'd1);
    send_item(1'b0, HdrByte0);
    send_frame(tracker.cfg.report_cmd, 1'b1);
    send_item(1'b1, 8'hFF);
    send_oversize(16'hFFFF);
    send_item(1'b0, HdrByte0);
    send_item(1'b0, 8'h13);
    payload_q.delete();
    send_frame(8'h00, 1'b0);
    run_traffic(50);

    reprogram(random_cfg());
    run_traffic(30);
    // receiver holds off while short frames keep coming
    hold_req = 1'b1;
    repeat (14) begin
      payload_q.delete();
      send_frame(tracker.cfg.report_cmd, 1'b1);
    end
    run_traffic(30);

    c = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd0, 24'd1, 8'd1};
    reprogram(c);
    run_traffic(30);

    quiet = 1'b1;
    c = '{8'd255, 8'd0, 8'd254, 8'd1, 8'd127, 8'd255, 24'hFF_FFFF, 8'd255};
    reprogram(c);
    send_long_frame();
    run_traffic(30);
    quiet = 1'b0;

    // limit of zero: every counted toggle raises the request
    c = random_cfg();
    c.limit = 8'd0;
    reprogram(c);
    run_traffic(30);

    reprogram(random_cfg());
    while (items_sent < ItemGoal) random_event();

    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/msfr_pkg.sv
rtl/msfr_parser.sv
rtl/msfr_state.sv
rtl/msfr_out_skid.sv
rtl/mcu_status_frame_receiver.sv
sim/msfr_tracker_pkg.sv
sim/tb_mcu_status_frame_receiver.sv
